[rtl/cse_pkg.sv]
package cse_pkg;

  localparam int unsigned MaxChars = 9;
  localparam int unsigned CountW   = $clog2(MaxChars + 1);
  localparam int unsigned IdxW     = $clog2(MaxChars);

  localparam logic [31:0] MaxShownReset = 32'hFFFF_FFFF;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuestion  = 8'h3F;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDel       = 8'h7F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] next_byte_1;
    logic [7:0] next_byte_2;
    logic [7:0] next_byte_3;
    logic [1:0] ahead_count;
    logic       has_byte;
    logic       last_item;
  } item_t;

  typedef struct packed {
    logic        started;
    logic [31:0] shown_count;
    logic        truncated;
    logic [1:0]  copy_remaining;
    logic        hex_pending;
    logic [1:0]  question_run;
  } esc_state_t;

  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CountW-1:0]        count;
    logic                     closes;
  } burst_t;

endpackage

[rtl/cse_in_if.sv]
interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] next_byte_1;
  logic [7:0] next_byte_2;
  logic [7:0] next_byte_3;
  logic [1:0] ahead_count;
  logic       has_byte;
  logic       last_item;

  modport source (
    output valid, data_byte, next_byte_1, next_byte_2, next_byte_3,
           ahead_count, has_byte, last_item,
    input  ready
  );
  modport sink (
    input  valid, data_byte, next_byte_1, next_byte_2, next_byte_3,
           ahead_count, has_byte, last_item,
    output ready
  );
endinterface

[rtl/cse_out_if.sv]
interface cse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_out;

  modport source (
    output valid, out_char, last_out,
    input  ready
  );
  modport sink (
    input  valid, out_char, last_out,
    output ready
  );
endinterface

[rtl/c_string_literal_escaper.sv]
// C string literal escaper.
// in_i carries one string byte per word with up to three look-ahead bytes,
// ahead_count, has_byte and last_item; out_o carries one character of the
// literal per word, with last_out on the last character of a literal.
// cfg_we_i / cfg_wdata_i write max_shown; write it only while idle.
// A word taken on in_i lands in an input register; from there it is
// expanded into a burst of 0 to 9 characters held in the result register,
// which drains one character per cycle while out_o is ready.
// The single-character result port limits the flow: a word yields one
// character for a plain byte, two for a backslash escape, four for \xHH,
// and up to nine with quotes and ellipsis. in_i takes the next word while
// a burst is still draining. If out_o stalls, the burst holds and in_i
// stops once the input register is full.
// Reset clears all escaping state, empties both registers and sets
// max_shown to all ones.
module c_string_literal_escaper
  import cse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cse_in_if.sink      in_i,
  cse_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0] max_shown_q;
  logic        in_valid_q;
  item_t       in_q;
  item_t       item;
  esc_state_t  state_q;
  esc_state_t  state_d;
  burst_t      burst;

  logic [MaxChars-1:0][7:0] chars_q;
  logic                     burst_valid_q;
  logic [IdxW-1:0]          idx_q;
  logic [IdxW-1:0]          last_idx_q;
  logic                     closes_q;

  logic in_ready;
  logic take;
  logic at_end;

  assign item = '{
    data_byte:   in_i.data_byte,
    next_byte_1: in_i.next_byte_1,
    next_byte_2: in_i.next_byte_2,
    next_byte_3: in_i.next_byte_3,
    ahead_count: in_i.ahead_count,
    has_byte:    in_i.has_byte,
    last_item:   in_i.last_item
  };

  cse_encode u_encode (
    .item_i      (in_q),
    .state_i     (state_q),
    .max_shown_i (max_shown_q),
    .burst_o     (burst),
    .state_o     (state_d)
  );

  assign at_end   = (idx_q == last_idx_q);
  assign take     = in_valid_q && (!burst_valid_q || (out_o.ready && at_end));
  assign in_ready = !in_valid_q || take;

  assign in_i.ready     = in_ready;
  assign out_o.valid    = burst_valid_q;
  assign out_o.out_char = chars_q[idx_q];
  assign out_o.last_out = closes_q && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_shown_q   <= MaxShownReset;
      in_valid_q    <= 1'b0;
      state_q       <= '0;
      burst_valid_q <= 1'b0;
      idx_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        max_shown_q <= cfg_wdata_i;
      end
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (take) begin
        state_q       <= state_d;
        burst_valid_q <= (burst.count != '0);
        idx_q         <= '0;
      end else if (burst_valid_q && out_o.ready) begin
        if (at_end) begin
          burst_valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_q <= item;
    end
    if (take) begin
      chars_q    <= burst.chars;
      last_idx_q <= IdxW'(burst.count - CountW'(1));
      closes_q   <= burst.closes;
    end
  end

endmodule

[rtl/cse_encode.sv]
module cse_encode
  import cse_pkg::*;
(
  input  item_t       item_i,
  input  esc_state_t  state_i,
  input  logic [31:0] max_shown_i,
  output burst_t      burst_o,
  output esc_state_t  state_o
);

  function automatic logic [2:0] seq_len(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [1:0] avail);
    logic [2:0]  len;
    logic [20:0] code;
    logic [20:0] lowest;
    logic        ok;
    len    = 3'd0;
    code   = '0;
    lowest = '0;
    ok     = 1'b0;
    if (b0[7:5] == 3'b110) begin
      len    = 3'd2;
      code   = {10'd0, b0[4:0], b1[5:0]};
      lowest = 21'h00080;
      ok     = (b1[7:6] == 2'b10);
    end else if (b0[7:4] == 4'b1110) begin
      len    = 3'd3;
      code   = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      lowest = 21'h00800;
      ok     = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10);
    end else if (b0[7:3] == 5'b11110) begin
      len    = 3'd4;
      code   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      lowest = 21'h10000;
      ok     = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) && (b3[7:6] == 2'b10);
    end
    if ({1'b0, avail} < (len - 3'd1)) ok = 1'b0;
    if (code < lowest) ok = 1'b0;
    if ((code >= 21'h0D800) && (code <= 21'h0DFFF)) ok = 1'b0;
    if (code > 21'h10FFFF) ok = 1'b0;
    return ok ? len : 3'd0;
  endfunction

  function automatic logic [7:0] esc_of(input logic [7:0] c);
    logic [7:0] e;
    unique case (c)
      8'h0D:       e = "r";
      8'h09:       e = "t";
      8'h07:       e = "a";
      8'h0C:       e = "f";
      8'h0B:       e = "v";
      8'h08:       e = "b";
      8'h0A:       e = "n";
      ChQuote:     e = ChQuote;
      ChBackslash: e = ChBackslash;
      default:     e = 8'h00;
    endcase
    return e;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_tri(input logic [7:0] c);
    return (c == 8'h3D) || (c == 8'h28) || (c == 8'h2F) || (c == 8'h29) ||
           (c == 8'h27) || (c == 8'h3C) || (c == 8'h21) || (c == 8'h3E) || (c == 8'h2D);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
  endfunction

  logic [7:0]        c;
  logic [7:0]        esc;
  logic [2:0]        len;
  logic [CountW-1:0] n;

  assign c   = item_i.data_byte;
  assign esc = esc_of(c);
  assign len = seq_len(c, item_i.next_byte_1, item_i.next_byte_2, item_i.next_byte_3,
                       item_i.ahead_count);

  always_comb begin
    burst_o = '0;
    state_o = state_i;
    n       = '0;

    if (!state_i.started) begin
      burst_o.chars[n[IdxW-1:0]] = ChQuote;
      n = n + CountW'(1);
      state_o.started = 1'b1;
    end

    if (item_i.has_byte) begin
      if (state_i.shown_count < max_shown_i) begin
        state_o.shown_count  = state_i.shown_count + 32'd1;
        state_o.question_run = 2'd0;
        state_o.hex_pending  = 1'b0;
        if (state_i.copy_remaining != 2'd0) begin
          burst_o.chars[n[IdxW-1:0]] = c;
          n = n + CountW'(1);
          state_o.copy_remaining = state_i.copy_remaining - 2'd1;
        end else if (esc != 8'h00) begin
          burst_o.chars[n[IdxW-1:0]] = ChBackslash;
          n = n + CountW'(1);
          burst_o.chars[n[IdxW-1:0]] = esc;
          n = n + CountW'(1);
        end else if ((c < ChSpace) || (c >= ChDel)) begin
          if (len > 3'd1) begin
            burst_o.chars[n[IdxW-1:0]] = c;
            n = n + CountW'(1);
            state_o.copy_remaining = 2'(len - 3'd1);
          end else begin
            burst_o.chars[n[IdxW-1:0]] = ChBackslash;
            n = n + CountW'(1);
            burst_o.chars[n[IdxW-1:0]] = ChLowerX;
            n = n + CountW'(1);
            burst_o.chars[n[IdxW-1:0]] = hex_digit(c[7:4]);
            n = n + CountW'(1);
            burst_o.chars[n[IdxW-1:0]] = hex_digit(c[3:0]);
            n = n + CountW'(1);
            state_o.hex_pending  = 1'b1;
            state_o.question_run = state_i.question_run;
          end
        end else begin
          if ((state_i.hex_pending && is_hex(c)) ||
              ((state_i.question_run == 2'd2) && is_tri(c))) begin
            burst_o.chars[n[IdxW-1:0]] = ChQuote;
            n = n + CountW'(1);
            burst_o.chars[n[IdxW-1:0]] = ChQuote;
            n = n + CountW'(1);
          end else if (c == ChQuestion) begin
            state_o.question_run = (state_i.question_run == 2'd2) ? 2'd2
                                 : state_i.question_run + 2'd1;
          end
          burst_o.chars[n[IdxW-1:0]] = c;
          n = n + CountW'(1);
        end
      end else begin
        state_o.truncated = 1'b1;
      end
    end

    if (item_i.last_item) begin
      burst_o.chars[n[IdxW-1:0]] = ChQuote;
      n = n + CountW'(1);
      if (state_o.truncated) begin
        burst_o.chars[n[IdxW-1:0]] = ChDot;
        n = n + CountW'(1);
        burst_o.chars[n[IdxW-1:0]] = ChDot;
        n = n + CountW'(1);
        burst_o.chars[n[IdxW-1:0]] = ChDot;
        n = n + CountW'(1);
      end
      burst_o.closes = 1'b1;
      state_o        = '0;
    end

    burst_o.count = n;
  end

endmodule

[tb/c_string_literal_escaper_tb.sv]
`timescale 1ns / 1ps

module c_string_literal_escaper_tb;
  import cse_pkg::*;

  localparam int DirN       = 25;
  localparam int PhaseWords = 35;
  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 2000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } lit_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  cse_in_if  in_bus ();
  cse_out_if out_bus ();

  c_string_literal_escaper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  esc_state_t  st;
  logic [31:0] max_shown_q;
  lit_char_t   literal_q[$];
  lit_char_t   word_chars[$];
  string       hex_digits = "0123456789abcdef";
  int          fail_count;
  int          random_words;
  int          idle_cycles;
  bit          idle_on;
  bit          hold_req;

  item_t dir_item [DirN] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 1'b1},
    '{8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1, 1'b1},
    '{8'h0A, 8'h0D, 8'h09, 8'h07, 2'd3, 1'b1, 1'b0},
    '{8'h0D, 8'h09, 8'h07, 8'h0C, 2'd3, 1'b1, 1'b0},
    '{8'h09, 8'h07, 8'h0C, 8'h0B, 2'd3, 1'b1, 1'b0},
    '{8'h07, 8'h0C, 8'h0B, 8'h08, 2'd3, 1'b1, 1'b0},
    '{8'h0C, 8'h0B, 8'h08, 8'h22, 2'd3, 1'b1, 1'b0},
    '{8'h0B, 8'h08, 8'h22, 8'h5C, 2'd3, 1'b1, 1'b0},
    '{8'h08, 8'h22, 8'h5C, 8'h7F, 2'd3, 1'b1, 1'b0},
    '{8'h22, 8'h5C, 8'h7F, 8'h00, 2'd2, 1'b1, 1'b0},
    '{8'h5C, 8'h7F, 8'h00, 8'h00, 2'd1, 1'b1, 1'b0},
    '{8'hAA, 8'h55, 8'hAA, 8'h55, 2'd2, 1'b0, 1'b0},
    '{8'h7F, 8'h00, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1},
    '{8'h01, 8'h61, 8'h00, 8'h00, 2'd1, 1'b1, 1'b0},
    '{8'h61, 8'h00, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1},
    '{8'h3F, 8'h3F, 8'h01, 8'h28, 2'd3, 1'b1, 1'b0},
    '{8'h3F, 8'h01, 8'h28, 8'h00, 2'd2, 1'b1, 1'b0},
    '{8'h01, 8'h28, 8'h00, 8'h00, 2'd1, 1'b1, 1'b0},
    '{8'h28, 8'h00, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1},
    '{8'hF0, 8'h9F, 8'h98, 8'h80, 2'd3, 1'b1, 1'b0},
    '{8'h9F, 8'h98, 8'h80, 8'h00, 2'd2, 1'b1, 1'b0},
    '{8'h98, 8'h80, 8'h00, 8'h00, 2'd1, 1'b1, 1'b0},
    '{8'h80, 8'h00, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1},
    '{8'hC3, 8'hA9, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1}
  };

  string dir_text [DirN] = '{
    "\"\"",
    "\"\\x00\"",
    "\"\\xff\"",
    "\"\\n",
    "\\r",
    "\\t",
    "\\a",
    "\\f",
    "\\v",
    "\\b",
    "\\\"",
    "\\\\",
    "",
    "\\x7f\"",
    "\"\\x01",
    "\"\"a\"",
    "", "", "", "",
    "", "", "", "",
    "\"\\xc3\""
  };

  function automatic void put(logic [7:0] ch);
    word_chars.push_back('{ch, 1'b0});
  endfunction

  function automatic void show_byte(item_t it);
    logic [7:0]  c;
    logic [7:0]  esc;
    logic [7:0]  nb [4];
    logic [31:0] code;
    logic [31:0] lowest;
    int          n;
    bit          ok;
    c = it.data_byte;
    esc = 8'h00;
    if (st.copy_remaining != 2'd0) begin
      put(c);
      st.copy_remaining = st.copy_remaining - 2'd1;
    end else begin
      case (c)
        8'h0D:       esc = "r";
        8'h09:       esc = "t";
        8'h07:       esc = "a";
        8'h0C:       esc = "f";
        8'h0B:       esc = "v";
        8'h08:       esc = "b";
        8'h0A:       esc = "n";
        ChQuote:     esc = ChQuote;
        ChBackslash: esc = ChBackslash;
        default:     esc = 8'h00;
      endcase
      if (esc != 8'h00) begin
        put(ChBackslash);
        put(esc);
      end else if (c < ChSpace || c >= ChDel) begin
        nb = '{c, it.next_byte_1, it.next_byte_2, it.next_byte_3};
        n = 0;
        code = 32'd0;
        lowest = 32'd0;
        if (c >= 8'hC0 && c <= 8'hDF) begin
          n = 2;
          code = {27'd0, c[4:0]};
          lowest = 32'h80;
        end else if (c >= 8'hE0 && c <= 8'hEF) begin
          n = 3;
          code = {28'd0, c[3:0]};
          lowest = 32'h800;
        end else if (c >= 8'hF0 && c <= 8'hF7) begin
          n = 4;
          code = {29'd0, c[2:0]};
          lowest = 32'h10000;
        end
        ok = (n != 0) && (n - 1 <= int'(it.ahead_count));
        for (int i = 1; i < 4; i++) begin
          if (i < n) begin
            if (nb[i][7:6] != 2'b10) ok = 1'b0;
            code = (code << 6) | {26'd0, nb[i][5:0]};
          end
        end
        if (code < lowest || (code >= 32'hD800 && code <= 32'hDFFF) || code > 32'h10FFFF) begin
          ok = 1'b0;
        end
        if (ok) begin
          put(c);
          st.copy_remaining = 2'(n - 1);
        end else begin
          put(ChBackslash);
          put(ChLowerX);
          put(hex_digits[c[7:4]]);
          put(hex_digits[c[3:0]]);
          st.hex_pending = 1'b1;
          return;
        end
      end else begin
        if ((st.hex_pending && (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]})) ||
            (st.question_run == 2'd2 &&
             (c inside {"=", "(", "/", ")", "'", "<", "!", ">", "-"}))) begin
          put(ChQuote);
          put(ChQuote);
        end else if (c == ChQuestion) begin
          if (st.question_run < 2'd2) st.question_run = st.question_run + 2'd1;
          put(c);
          st.hex_pending = 1'b0;
          return;
        end
        put(c);
      end
    end
    st.question_run = 2'd0;
    st.hex_pending = 1'b0;
  endfunction

  function automatic void escape_item(item_t it);
    word_chars.delete();
    if (!st.started) begin
      put(ChQuote);
      st.started = 1'b1;
    end
    if (it.has_byte) begin
      if (st.shown_count < max_shown_q) begin
        show_byte(it);
        st.shown_count = st.shown_count + 32'd1;
      end else begin
        st.truncated = 1'b1;
      end
    end
    if (it.last_item) begin
      put(ChQuote);
      if (st.truncated) repeat (3) put(ChDot);
      word_chars[word_chars.size() - 1].last = 1'b1;
      st = '0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void check_char(logic [7:0] ch, logic last);
    lit_char_t exp_c;
    if (literal_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected char %h last %b", ch, last);
    end else begin
      exp_c = literal_q.pop_front();
      if (exp_c.ch !== ch || exp_c.last !== last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: expected %h last %b, got %h last %b",
                   exp_c.ch, exp_c.last, ch, last);
        end
      end
    end
  endfunction

  task automatic send_item(item_t it, string typed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.data_byte   <= it.data_byte;
    in_bus.next_byte_1 <= it.next_byte_1;
    in_bus.next_byte_2 <= it.next_byte_2;
    in_bus.next_byte_3 <= it.next_byte_3;
    in_bus.ahead_count <= it.ahead_count;
    in_bus.has_byte    <= it.has_byte;
    in_bus.last_item   <= it.last_item;
    do @(posedge clk_i); while (!in_bus.ready);
    escape_item(it);
    if (typed.len() == 0) begin
      foreach (word_chars[k]) literal_q.push_back(word_chars[k]);
    end else begin
      for (int k = 0; k < typed.len(); k++) begin
        literal_q.push_back('{typed[k], it.last_item && (k == typed.len() - 1)});
      end
    end
  endtask

  task automatic write_max_shown(logic [31:0] value);
    in_bus.valid <= 1'b0;
    while (literal_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_shown_q = value;
  endtask

  task automatic add_text_bytes(ref logic [7:0] text[$]);
    string picks;
    int    n;
    picks = "0123456789abcdefABCDEF=(/)'<!>-";
    case ($urandom_range(0, 9))
      0, 1, 2: text.push_back(8'($urandom_range(32, 126)));
      3:       text.push_back(ChQuestion);
      4:       text.push_back(picks[$urandom_range(0, picks.len() - 1)]);
      5:       text.push_back(8'($urandom_range(0, 31)));
      6:       text.push_back(8'($urandom_range(127, 255)));
      default: begin
        n = $urandom_range(2, 4);
        case (n)
          2:       text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          3:       text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          default: text.push_back(8'($urandom_range(8'hF0, 8'hF7)));
        endcase
        repeat (n - 1) begin
          if ($urandom_range(0, 7) == 0) text.push_back(8'($urandom));
          else text.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
      end
    endcase
  endtask

  task automatic send_string();
    logic [7:0] text[$];
    item_t      it;
    int         len;
    int         rest;
    len = $urandom_range(0, 12);
    while (text.size() < len) add_text_bytes(text);
    if (text.size() == 0) begin
      it = item_t'({$urandom, 4'($urandom)});
      it.has_byte  = 1'b0;
      it.last_item = 1'b1;
      send_item(it, "");
      random_words++;
    end
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(0, 14) == 0) begin
        it = item_t'({$urandom, 4'($urandom)});
        it.has_byte  = 1'b0;
        it.last_item = 1'b0;
        send_item(it, "");
      end
      rest = text.size() - 1 - i;
      it.data_byte   = text[i];
      it.next_byte_1 = (rest >= 1) ? text[i + 1] : 8'($urandom);
      it.next_byte_2 = (rest >= 2) ? text[i + 2] : 8'($urandom);
      it.next_byte_3 = (rest >= 3) ? text[i + 3] : 8'($urandom);
      it.ahead_count = (rest > 3) ? 2'd3 : 2'(rest);
      if ($urandom_range(0, 9) == 0) it.ahead_count = 2'($urandom);
      it.has_byte  = 1'b1;
      it.last_item = (rest == 0);
      send_item(it, "");
      random_words++;
    end
  endtask

  initial begin
    int          stall;
    bit          held;
    stall = 0;
    held = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) check_char(out_bus.out_char, out_bus.last_out);
      if (hold_req && !held) begin
        held = 1'b1;
        stall = HoldCycles;
      end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] lim;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.data_byte   <= '0;
    in_bus.next_byte_1 <= '0;
    in_bus.next_byte_2 <= '0;
    in_bus.next_byte_3 <= '0;
    in_bus.ahead_count <= '0;
    in_bus.has_byte    <= 1'b0;
    in_bus.last_item   <= 1'b0;
    random_words = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    st = '0;
    max_shown_q = MaxShownReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirN; i++) send_item(dir_item[i], dir_text[i]);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       lim = 32'd0;
        1:       lim = 32'd1;
        2:       lim = 32'($urandom_range(2, 8));
        3:       lim = 32'($urandom_range(9, 64));
        4:       lim = 32'h8000_0000;
        default: lim = MaxShownReset;
      endcase
      write_max_shown(lim);
      // phase 4: no idling, receiver holds off so the block backs up
      idle_on = (p != 4);
      hold_req = (p == 4);
      random_words = 0;
      while (random_words < PhaseWords) send_string();
    end

    in_bus.valid <= 1'b0;
    while (literal_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && literal_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[c_string_literal_escaper.f]
rtl/cse_pkg.sv
rtl/cse_in_if.sv
rtl/cse_out_if.sv
rtl/cse_encode.sv
rtl/c_string_literal_escaper.sv
tb/c_string_literal_escaper_tb.sv
